FILE: sv/gwb_pkg.sv
// Package for the grey point white balance block: shared types, register
// indexes, reset values and fixed widths. No dependencies.
`timescale 1ns / 1ps

package gwb_pkg;

  localparam int SUM_W   = 38;
  localparam int CNT_W   = 21;
  localparam int GAIN_W  = 16;
  localparam int CHR_W   = 18;
  localparam int PROD_W  = 37;
  localparam int DELTA_W = 18;

  localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd256;

  localparam logic [2:0] REG_GREY_LIMIT   = 3'd0;
  localparam logic [2:0] REG_STRONG_ERROR = 3'd1;
  localparam logic [2:0] REG_WEAK_ERROR   = 3'd2;
  localparam logic [2:0] REG_STEP_SIZE    = 3'd3;
  localparam logic [2:0] REG_GAIN_FLOOR   = 3'd4;
  localparam logic [2:0] REG_GAIN_CEILING = 3'd5;

  localparam logic [15:0] RST_GREY_LIMIT   = 16'd18042;
  localparam logic [15:0] RST_STRONG_ERROR = 16'd205;
  localparam logic [15:0] RST_WEAK_ERROR   = 16'd26;
  localparam logic [15:0] RST_STEP_SIZE    = 16'd200;
  localparam logic [15:0] RST_GAIN_FLOOR   = 16'd0;
  localparam logic [15:0] RST_GAIN_CEILING = 16'd65535;

  localparam logic [1:0] CHAN_NONE = 2'd0;
  localparam logic [1:0] CHAN_BLUE = 2'd1;
  localparam logic [1:0] CHAN_RED  = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_GREY = 1'b1;

  typedef struct packed {
    logic [15:0] grey_limit;
    logic [15:0] strong_error;
    logic [15:0] weak_error;
    logic [15:0] step_size;
    logic [15:0] gain_floor;
    logic [15:0] gain_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
    logic       sample;
  } pix_t;

  typedef struct packed {
    logic                    vld;
    logic                    last;
    logic                    grey;
    logic signed [CHR_W-1:0] u;
    logic signed [CHR_W-1:0] v;
  } grey_t;

  typedef struct packed {
    logic                    vld;
    logic signed [SUM_W-1:0] su;
    logic signed [SUM_W-1:0] sv;
    logic [CNT_W-1:0]        n;
  } frame_t;

  typedef struct packed {
    logic              status;
    logic [1:0]        chan;
    logic [GAIN_W-1:0] red_now;
    logic [GAIN_W-1:0] blue_now;
  } res_t;

endpackage

FILE: sv/gwb_grey_detect.sv
// Pixel front end: input register, luma and chroma, and the grey point test.
// Depends on gwb_pkg.
`timescale 1ns / 1ps

module gwb_grey_detect (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           take,
  input  gwb_pkg::pix_t  pix,
  input  logic [15:0]    grey_limit,
  output gwb_pkg::grey_t grey
);
  import gwb_pkg::*;

  logic                    vld1_r, vld2_r, vld3_r, vld4_r;
  pix_t                    p1_r;
  logic [15:0]             y2_r;
  logic signed [CHR_W-1:0] u2_r, v2_r, u3_r, v3_r, u4_r, v4_r;
  logic [CHR_W-1:0]        chr2_r, chr3_r;
  logic                    smp2_r, smp3_r, last2_r, last3_r, last4_r;
  logic                    ynz3_r, grey4_r;
  logic [31:0]             prod3_r;

  logic [15:0]             y_nxt;
  logic signed [CHR_W-1:0] u_nxt, v_nxt;
  logic [CHR_W-1:0]        ua, va;
  logic                    grey_nxt;

  always_comb begin
    y_nxt = ({8'd0, p1_r.red} * 16'd77) + ({8'd0, p1_r.green} * 16'd150)
          + ({8'd0, p1_r.blue} * 16'd29);
    u_nxt = $signed({2'b00, p1_r.blue, 8'd0}) - $signed({2'b00, y_nxt});
    v_nxt = $signed({2'b00, p1_r.red, 8'd0}) - $signed({2'b00, y_nxt});
    ua    = u_nxt[CHR_W-1] ? CHR_W'(-u_nxt) : CHR_W'(u_nxt);
    va    = v_nxt[CHR_W-1] ? CHR_W'(-v_nxt) : CHR_W'(v_nxt);
    grey_nxt = smp3_r && ynz3_r && ({chr3_r, 16'd0} < {2'b00, prod3_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= take;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r    <= pix;
      y2_r    <= y_nxt;
      u2_r    <= u_nxt;
      v2_r    <= v_nxt;
      chr2_r  <= ua + va;
      smp2_r  <= p1_r.sample;
      last2_r <= p1_r.last;
      prod3_r <= 32'(grey_limit) * 32'(y2_r);
      ynz3_r  <= y2_r != 16'd0;
      chr3_r  <= chr2_r;
      u3_r    <= u2_r;
      v3_r    <= v2_r;
      smp3_r  <= smp2_r;
      last3_r <= last2_r;
      grey4_r <= grey_nxt;
      u4_r    <= u3_r;
      v4_r    <= v3_r;
      last4_r <= last3_r;
    end
  end

  assign grey.vld  = vld4_r;
  assign grey.last = last4_r;
  assign grey.grey = grey4_r;
  assign grey.u    = u4_r;
  assign grey.v    = v4_r;

endmodule

FILE: sv/gwb_gain_ctrl.sv
// Frame end path: channel choice, error weight, gain step and clamp, and the
// result register. Depends on gwb_pkg.
`timescale 1ns / 1ps

module gwb_gain_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  gwb_pkg::frame_t frame,
  input  gwb_pkg::cfg_t   cfg,
  output logic            res_vld,
  output gwb_pkg::res_t   res
);
  import gwb_pkg::*;

  logic                f2_vld_r, f2_status_r, f2_pos_r, f2_neg_r;
  logic [1:0]          f2_chan_r;
  logic [SUM_W-1:0]    f2_m_r;
  logic [PROD_W-1:0]   f2_ps_r, f2_pw_r;
  logic                f3_vld_r, f3_status_r, f3_dec_r;
  logic [1:0]          f3_chan_r;
  logic [DELTA_W-1:0]  f3_delta_r;
  logic                out_vld_r;
  res_t                res_r;
  logic [GAIN_W-1:0]   red_gain_r, blue_gain_r;

  logic [SUM_W-1:0]        mu, mv, m_nxt;
  logic signed [SUM_W-1:0] s_sel;
  logic [1:0]              chan_nxt;
  logic                    status_nxt;
  logic [DELTA_W-1:0]      delta_nxt;
  logic                    w2, w1;
  logic [GAIN_W-1:0]       gain_old, gain_new, red_nxt, blue_nxt;
  logic signed [25:0]      t;
  logic signed [17:0]      q;

  always_comb begin
    mu = frame.su[SUM_W-1] ? SUM_W'(-frame.su) : SUM_W'(frame.su);
    mv = frame.sv[SUM_W-1] ? SUM_W'(-frame.sv) : SUM_W'(frame.sv);
    status_nxt = (frame.n == '0) ? STATUS_NO_GREY : STATUS_OK;
    if (status_nxt == STATUS_NO_GREY) begin
      chan_nxt = CHAN_NONE;
    end else if (mu > mv) begin
      chan_nxt = CHAN_BLUE;
    end else if (mv > mu) begin
      chan_nxt = CHAN_RED;
    end else begin
      chan_nxt = CHAN_NONE;
    end
    s_sel = (chan_nxt == CHAN_BLUE) ? frame.su : frame.sv;
    m_nxt = (chan_nxt == CHAN_BLUE) ? mu : mv;
  end

  always_comb begin
    w2 = f2_m_r > {1'b0, f2_ps_r};
    w1 = (f2_m_r >= {1'b0, f2_pw_r}) && (f2_m_r < {1'b0, f2_ps_r});
    if (!f2_pos_r && !f2_neg_r) begin
      delta_nxt = '0;
    end else if (w2) begin
      delta_nxt = {1'b0, cfg.step_size, 1'b0};
    end else if (w1) begin
      delta_nxt = {2'b00, cfg.step_size};
    end else begin
      delta_nxt = '0;
    end
  end

  always_comb begin
    gain_old = (f3_chan_r == CHAN_BLUE) ? blue_gain_r : red_gain_r;
    if (f3_dec_r) begin
      t = $signed({2'b00, gain_old, 8'd0}) - $signed({8'd0, f3_delta_r});
    end else begin
      t = $signed({2'b00, gain_old, 8'd0}) + $signed({8'd0, f3_delta_r});
    end
    q = t[25:8];
    if (q > $signed({2'b00, cfg.gain_ceiling})) begin
      gain_new = cfg.gain_ceiling;
    end else if (q < $signed({2'b00, cfg.gain_floor})) begin
      gain_new = cfg.gain_floor;
    end else begin
      gain_new = q[GAIN_W-1:0];
    end
    red_nxt  = (f3_chan_r == CHAN_RED) ? gain_new : red_gain_r;
    blue_nxt = (f3_chan_r == CHAN_BLUE) ? gain_new : blue_gain_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r    <= 1'b0;
      f3_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      red_gain_r  <= GAIN_UNITY;
      blue_gain_r <= GAIN_UNITY;
    end else if (adv) begin
      f2_vld_r  <= frame.vld;
      f3_vld_r  <= f2_vld_r;
      out_vld_r <= f3_vld_r;
      if (f3_vld_r) begin
        red_gain_r  <= red_nxt;
        blue_gain_r <= blue_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_status_r <= status_nxt;
      f2_chan_r   <= chan_nxt;
      f2_m_r      <= m_nxt;
      f2_neg_r    <= s_sel[SUM_W-1];
      f2_pos_r    <= !s_sel[SUM_W-1] && (s_sel != '0);
      f2_ps_r     <= PROD_W'(cfg.strong_error) * PROD_W'(frame.n);
      f2_pw_r     <= PROD_W'(cfg.weak_error) * PROD_W'(frame.n);
      f3_status_r <= f2_status_r;
      f3_chan_r   <= f2_chan_r;
      f3_dec_r    <= f2_pos_r;
      f3_delta_r  <= delta_nxt;
      if (f3_vld_r) begin
        res_r.status   <= f3_status_r;
        res_r.chan     <= f3_chan_r;
        res_r.red_now  <= red_nxt;
        res_r.blue_now <= blue_nxt;
      end
    end
  end

  assign res_vld = out_vld_r;
  assign res     = res_r;

endmodule

FILE: sv/grey_point_white_balance_top.sv
// Top level of the grey point white balance block: configuration registers,
// sample phase, frame accumulators. Depends on gwb_pkg, gwb_grey_detect and
// gwb_gain_ctrl.
//
//   channel   direction  handshake              payload
//   in_       input      in_valid / in_stall    pixel_blue/green/red, frame_last
//   out_      output     out_valid / out_stall  status, adjusted_channel, gains
//   cfg_      APB        psel, penable, pready  paddr, pwdata, prdata
//
// One pixel is taken every cycle that in_stall is low. A frame's result passes
// the grey detect stages, frame register and gain control stages to the output.
// Reset clears the accumulators, sample phase and all valid bits, and sets both
// gains to 256. While a result waits in the output register with out_stall high,
// the whole pipeline holds and in_stall is high.
`timescale 1ns / 1ps

module grey_point_white_balance_top #(
  parameter int SAMPLE_STRIDE = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel_blue,
  input  logic [7:0]  in_pixel_green,
  input  logic [7:0]  in_pixel_red,
  input  logic        in_frame_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [1:0]  out_adjusted_channel,
  output logic [15:0] out_red_gain_now,
  output logic [15:0] out_blue_gain_now,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gwb_pkg::*;

  localparam int PH_W = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(SAMPLE_STRIDE - 1);

  cfg_t                    cfg_r;
  logic [PH_W-1:0]         phase_r;
  logic signed [SUM_W-1:0] acc_u_r, acc_v_r, acc_u_nxt, acc_v_nxt;
  logic [CNT_W-1:0]        acc_n_r, acc_n_nxt;
  frame_t                  frame_r;
  logic                    adv, take, add, wr_en, res_vld;
  logic [2:0]              idx;
  pix_t                    pix;
  grey_t                   grey;
  res_t                    res;

  assign adv      = !(res_vld && out_stall);
  assign in_stall = !adv;
  assign take     = in_valid && adv;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grey_limit   <= RST_GREY_LIMIT;
      cfg_r.strong_error <= RST_STRONG_ERROR;
      cfg_r.weak_error   <= RST_WEAK_ERROR;
      cfg_r.step_size    <= RST_STEP_SIZE;
      cfg_r.gain_floor   <= RST_GAIN_FLOOR;
      cfg_r.gain_ceiling <= RST_GAIN_CEILING;
    end else if (wr_en) begin
      unique case (idx)
        REG_GREY_LIMIT:   cfg_r.grey_limit   <= cfg_pwdata[15:0];
        REG_STRONG_ERROR: cfg_r.strong_error <= cfg_pwdata[15:0];
        REG_WEAK_ERROR:   cfg_r.weak_error   <= cfg_pwdata[15:0];
        REG_STEP_SIZE:    cfg_r.step_size    <= cfg_pwdata[15:0];
        REG_GAIN_FLOOR:   cfg_r.gain_floor   <= cfg_pwdata[15:0];
        REG_GAIN_CEILING: cfg_r.gain_ceiling <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GREY_LIMIT:   cfg_prdata = {16'd0, cfg_r.grey_limit};
      REG_STRONG_ERROR: cfg_prdata = {16'd0, cfg_r.strong_error};
      REG_WEAK_ERROR:   cfg_prdata = {16'd0, cfg_r.weak_error};
      REG_STEP_SIZE:    cfg_prdata = {16'd0, cfg_r.step_size};
      REG_GAIN_FLOOR:   cfg_prdata = {16'd0, cfg_r.gain_floor};
      REG_GAIN_CEILING: cfg_prdata = {16'd0, cfg_r.gain_ceiling};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (take) begin
      if (in_frame_last || (phase_r == PH_LAST)) begin
        phase_r <= '0;
      end else begin
        phase_r <= phase_r + 1'b1;
      end
    end
  end

  assign pix.blue   = in_pixel_blue;
  assign pix.green  = in_pixel_green;
  assign pix.red    = in_pixel_red;
  assign pix.last   = in_frame_last;
  assign pix.sample = phase_r == '0;

  gwb_grey_detect u_grey_detect (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .take       (take),
    .pix        (pix),
    .grey_limit (cfg_r.grey_limit),
    .grey       (grey)
  );

  always_comb begin
    add       = grey.grey && (acc_n_r != COUNT_MAX);
    acc_u_nxt = add ? acc_u_r + SUM_W'(grey.u) : acc_u_r;
    acc_v_nxt = add ? acc_v_r + SUM_W'(grey.v) : acc_v_r;
    acc_n_nxt = add ? acc_n_r + 1'b1 : acc_n_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_u_r     <= '0;
      acc_v_r     <= '0;
      acc_n_r     <= '0;
      frame_r.vld <= 1'b0;
    end else if (adv) begin
      frame_r.vld <= grey.vld && grey.last;
      frame_r.su  <= acc_u_nxt;
      frame_r.sv  <= acc_v_nxt;
      frame_r.n   <= acc_n_nxt;
      if (grey.vld) begin
        if (grey.last) begin
          acc_u_r <= '0;
          acc_v_r <= '0;
          acc_n_r <= '0;
        end else begin
          acc_u_r <= acc_u_nxt;
          acc_v_r <= acc_v_nxt;
          acc_n_r <= acc_n_nxt;
        end
      end
    end
  end

  gwb_gain_ctrl u_gain_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .frame   (frame_r),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  assign out_valid            = res_vld;
  assign out_status           = res.status;
  assign out_adjusted_channel = res.chan;
  assign out_red_gain_now     = res.red_now;
  assign out_blue_gain_now    = res.blue_now;

endmodule
